/* sv/tpdl_pkg.sv */
// ----------------------------------------------------------------------------
// tpdl_pkg
// Shared types, widths and helpers of the weighted tree path distance block.
// ----------------------------------------------------------------------------
package tpdl_pkg;

  // field widths
  localparam int unsigned ID_W  = 12;
  localparam int unsigned WGT_W = 16;
  localparam int unsigned SUM_W = 28;
  localparam int unsigned DEP_W = 12;

  // stream word layout
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned NODE_LSB   = 0;
  localparam int unsigned PAR_LSB    = 12;
  localparam int unsigned WGT_LSB    = 24;
  localparam int unsigned QA_LSB     = 40;
  localparam int unsigned QB_LSB     = 52;

  // defaults of the top level parameters
  localparam int unsigned NODES_DEF  = 4096;
  localparam int unsigned LEVELS_DEF = 12;

  // bound on the steps of one lifting phase
  localparam int unsigned STEP_LIMIT = 4096;
  localparam int unsigned STEP_W     = 13;

  localparam logic [SUM_W-1:0] WEIGHT_MAX = {SUM_W{1'b1}};
  localparam logic [DEP_W-1:0] DEPTH_MAX  = {DEP_W{1'b1}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // one entry of the lifting table: 2^i-th ancestor and jump weight
  typedef struct packed {
    logic [ID_W-1:0]  anc;
    logic [SUM_W-1:0] wgt;
  } lift_ent_t;

  // saturating weight add
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? WEIGHT_MAX : s[SUM_W-1:0];
  endfunction

  // saturating depth increment
  function automatic logic [DEP_W-1:0] depth_inc(input logic [DEP_W-1:0] d);
    return (d == DEPTH_MAX) ? DEPTH_MAX : d + DEP_W'(1);
  endfunction

endpackage

/* sv/tpdl_ram.sv */
// ----------------------------------------------------------------------------
// tpdl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpdl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/tree_path_distance_lifting.sv */
// ----------------------------------------------------------------------------
// tree_path_distance_lifting
// Weighted tree path length between two nodes by binary lifting.
// ----------------------------------------------------------------------------
// The slave stream takes one word per operation: tuser 0 loads a node below
// an already loaded parent, tuser 1 asks for the path length between two
// nodes. A load gives no result word, a query gives one word on the master
// stream. Node 0 is the root and reads as all zero without being loaded.
// A load writes the depth and level zero together, then each higher level
// of the lifting table takes a read and a write through its single read
// port; a load to the root is dropped.
// A query reads both endpoint depths, then runs depth lifting steps and
// meeting steps, each scanning up to LEVELS levels of the lifting table; its
// pace is set by the one read port of the lifting table and the depth table
// lookup after each entry read.
// Every weight add goes through one shared saturating adder.
// tready is high only while the sequencer is idle. A finished result sits
// in an output register; the next word is taken while it waits, and a later
// query holds in its final state until that register is free.
// Reset clears the sequencer and the output valid flag; the tables need no
// clearing pass since only the root is read before being written.
// ----------------------------------------------------------------------------
module tree_path_distance_lifting #(
  parameter int unsigned NODES  = tpdl_pkg::NODES_DEF,
  parameter int unsigned LEVELS = tpdl_pkg::LEVELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: node_id, parent_id, edge_weight, query_first, query_second
  input  logic [tpdl_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // tuser: operation
  input  logic                             s_axis_tuser_i,
  // master stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: path_length, zero padded
  output logic [tpdl_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);

  import tpdl_pkg::*;

  localparam int unsigned NODE_AW = $clog2(NODES);
  localparam int unsigned LV_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned LVC_W   = $clog2(LEVELS + 1);
  localparam int unsigned LIFT_AW = NODE_AW + LV_W;
  localparam int unsigned LIFT_D  = NODES * (2 ** LV_W);
  localparam int unsigned ENT_W   = $bits(lift_ent_t);

  typedef enum logic [17:0] {
    ST_IDLE   = 18'b000000000000000001,
    ST_LD_DEP = 18'b000000000000000010,
    ST_LD_RD  = 18'b000000000000000100,
    ST_LD_WR  = 18'b000000000000001000,
    ST_QD_A   = 18'b000000000000010000,
    ST_QD_B   = 18'b000000000000100000,
    ST_P1_TOP = 18'b000000000001000000,
    ST_P1_RL  = 18'b000000000010000000,
    ST_P1_RD  = 18'b000000000100000000,
    ST_P1_CK  = 18'b000000001000000000,
    ST_P1_JMP = 18'b000000010000000000,
    ST_P2_TOP = 18'b000000100000000000,
    ST_P2_RX  = 18'b000001000000000000,
    ST_P2_RY  = 18'b000010000000000000,
    ST_P2_CK  = 18'b000100000000000000,
    ST_P2_JX  = 18'b001000000000000000,
    ST_P2_JY  = 18'b010000000000000000,
    ST_FIN    = 18'b100000000000000000
  } state_e;

  // node id to table address
  function automatic logic [NODE_AW-1:0] node_addr(input logic [ID_W-1:0] id);
    logic [NODE_AW+ID_W-1:0] ext;
    ext = {{NODE_AW{1'b0}}, id};
    return ext[NODE_AW-1:0];
  endfunction

  function automatic logic in_range(input logic [ID_W-1:0] id);
    return {{(32-ID_W){1'b0}}, id} < 32'(NODES);
  endfunction

  state_e           state_q, state_d;
  logic [ID_W-1:0]  node_q, node_d;
  logic [ID_W-1:0]  par_q, par_d;
  logic [ID_W-1:0]  qa_q, qa_d;
  logic [ID_W-1:0]  qb_q, qb_d;
  logic [ID_W-1:0]  mid_q, mid_d;
  logic [ID_W-1:0]  x_q, x_d;
  logic [ID_W-1:0]  y_q, y_d;
  logic [DEP_W-1:0] dx_q, dx_d;
  logic [DEP_W-1:0] dy_q, dy_d;
  logic [DEP_W-1:0] cdep_q, cdep_d;
  logic [SUM_W-1:0] wacc_q, wacc_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [LVC_W-1:0] lvl_q, lvl_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  lift_ent_t        ent_q, ent_d;
  lift_ent_t        candx_q, candx_d;
  lift_ent_t        candy_q, candy_d;
  logic             out_valid_q, out_valid_d;
  logic [SUM_W-1:0] out_data_q, out_data_d;

  // input word fields
  logic              in_op;
  logic [ID_W-1:0]   in_node, in_par, in_qa, in_qb;
  logic [WGT_W-1:0]  in_wgt;

  assign in_op   = s_axis_tuser_i;
  assign in_node = s_axis_tdata_i[NODE_LSB +: ID_W];
  assign in_par  = s_axis_tdata_i[PAR_LSB +: ID_W];
  assign in_wgt  = s_axis_tdata_i[WGT_LSB +: WGT_W];
  assign in_qa   = s_axis_tdata_i[QA_LSB +: ID_W];
  assign in_qb   = s_axis_tdata_i[QB_LSB +: ID_W];

  // table ports
  logic               lift_we, lift_re;
  logic [LIFT_AW-1:0] lift_waddr, lift_raddr;
  lift_ent_t          lift_wdata, lift_raw, lift_rd;
  logic               dep_we, dep_re;
  logic [NODE_AW-1:0] dep_waddr, dep_raddr;
  logic [DEP_W-1:0]   dep_wdata, dep_raw, dep_rd;
  logic [ID_W-1:0]    lift_node, dep_node;

  // shared saturating adder
  logic [SUM_W-1:0]   add_a, add_b, add_sum;

  // level counter as table index
  logic [LVC_W-1:0]   lvl_m1;
  logic [LV_W-1:0]    lvl_idx, lvl_m1_idx;
  logic               lvl_last;
  logic               brk;

  assign lvl_m1     = lvl_q - LVC_W'(1);
  assign lvl_idx    = lvl_q[LV_W-1:0];
  assign lvl_m1_idx = lvl_m1[LV_W-1:0];
  assign lvl_last   = (lvl_q == LVC_W'(LEVELS - 1));

  tpdl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (LIFT_D)
  ) u_lift_ram (
    .clk_i   (clk_i),
    .we_i    (lift_we),
    .waddr_i (lift_waddr),
    .wdata_i (lift_wdata),
    .re_i    (lift_re),
    .raddr_i (lift_raddr),
    .rdata_o (lift_raw)
  );

  tpdl_ram #(
    .WIDTH (DEP_W),
    .DEPTH (NODES)
  ) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .re_i    (dep_re),
    .raddr_i (dep_raddr),
    .rdata_o (dep_raw)
  );

  // node whose row the read data belongs to; the root reads as zero
  always_comb begin
    case (state_q)
      ST_LD_WR: lift_node = mid_q;
      ST_P2_CK: lift_node = y_q;
      default:  lift_node = x_q;
    endcase
    case (state_q)
      ST_LD_DEP: dep_node = par_q;
      ST_QD_A:   dep_node = qa_q;
      ST_QD_B:   dep_node = qb_q;
      default:   dep_node = ent_q.anc;
    endcase
  end

  assign lift_rd = (lift_node == '0) ? '0 : lift_raw;
  assign dep_rd  = (dep_node == '0) ? '0 : dep_raw;

  // adder operand select
  always_comb begin
    add_a = sum_q;
    case (state_q)
      ST_LD_WR: begin
        add_a = wacc_q;
        add_b = lift_rd.wgt;
      end
      ST_P2_JY: add_b = candy_q.wgt;
      default:  add_b = candx_q.wgt;
    endcase
  end

  assign add_sum = sat_add(add_a, add_b);

  // sequencer
  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    par_d       = par_q;
    qa_d        = qa_q;
    qb_d        = qb_q;
    mid_d       = mid_q;
    x_d         = x_q;
    y_d         = y_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    cdep_d      = cdep_q;
    wacc_d      = wacc_q;
    sum_d       = sum_q;
    lvl_d       = lvl_q;
    steps_d     = steps_q;
    ent_d       = ent_q;
    candx_d     = candx_q;
    candy_d     = candy_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    brk         = 1'b0;

    lift_we    = 1'b0;
    lift_waddr = '0;
    lift_wdata = '0;
    lift_re    = 1'b0;
    lift_raddr = '0;
    dep_we     = 1'b0;
    dep_waddr  = '0;
    dep_wdata  = '0;
    dep_re     = 1'b0;
    dep_raddr  = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          node_d = in_node;
          par_d  = in_par;
          qa_d   = in_qa;
          qb_d   = in_qb;
          wacc_d = {{(SUM_W-WGT_W){1'b0}}, in_wgt};
          if (in_op == OP_LOAD) begin
            if (in_node != '0 && in_range(in_node) && in_range(in_par)) begin
              dep_re    = 1'b1;
              dep_raddr = node_addr(in_par);
              state_d   = ST_LD_DEP;
            end
          end else if (in_range(in_qa) && in_range(in_qb)) begin
            dep_re    = 1'b1;
            dep_raddr = node_addr(in_qa);
            state_d   = ST_QD_A;
          end else begin
            sum_d   = '0;
            state_d = ST_FIN;
          end
        end
      end

      // load: depth and level zero
      ST_LD_DEP: begin
        dep_we     = 1'b1;
        dep_waddr  = node_addr(node_q);
        dep_wdata  = depth_inc(dep_rd);
        lift_we    = 1'b1;
        lift_waddr = {node_addr(node_q), LV_W'(0)};
        lift_wdata = '{anc: par_q, wgt: wacc_q};
        mid_d      = par_q;
        lvl_d      = LVC_W'(1);
        state_d    = (LEVELS == 1) ? ST_IDLE : ST_LD_RD;
      end

      // load: fetch the mid node's entry one level down
      ST_LD_RD: begin
        lift_re    = 1'b1;
        lift_raddr = {node_addr(mid_q), lvl_m1_idx};
        state_d    = ST_LD_WR;
      end

      // load: combine and write this level
      ST_LD_WR: begin
        lift_we    = 1'b1;
        lift_waddr = {node_addr(node_q), lvl_idx};
        lift_wdata = '{anc: lift_rd.anc, wgt: add_sum};
        mid_d      = lift_rd.anc;
        wacc_d     = add_sum;
        lvl_d      = lvl_q + LVC_W'(1);
        state_d    = lvl_last ? ST_IDLE : ST_LD_RD;
      end

      // query: endpoint depths
      ST_QD_A: begin
        dx_d      = dep_rd;
        dep_re    = 1'b1;
        dep_raddr = node_addr(qb_q);
        state_d   = ST_QD_B;
      end

      ST_QD_B: begin
        if (dep_rd > dx_q) begin
          x_d  = qb_q;
          y_d  = qa_q;
          dx_d = dep_rd;
          dy_d = dx_q;
        end else begin
          x_d  = qa_q;
          y_d  = qb_q;
          dy_d = dep_rd;
        end
        steps_d = '0;
        sum_d   = '0;
        state_d = ST_P1_TOP;
      end

      // phase one: lift the deeper node to equal depth
      ST_P1_TOP: begin
        if (steps_q == STEP_W'(STEP_LIMIT) || !(dx_q > dy_q)) begin
          steps_d = '0;
          state_d = ST_P2_TOP;
        end else begin
          lvl_d   = '0;
          state_d = ST_P1_RL;
        end
      end

      ST_P1_RL: begin
        lift_re    = 1'b1;
        lift_raddr = {node_addr(x_q), lvl_idx};
        state_d    = ST_P1_RD;
      end

      ST_P1_RD: begin
        ent_d     = lift_rd;
        dep_re    = 1'b1;
        dep_raddr = node_addr(lift_rd.anc);
        state_d   = ST_P1_CK;
      end

      ST_P1_CK: begin
        brk = dep_rd < dy_q;
        if (lvl_q == '0 || !brk) begin
          candx_d = ent_q;
          cdep_d  = dep_rd;
        end
        if (brk || lvl_last) begin
          state_d = ST_P1_JMP;
        end else begin
          lvl_d   = lvl_q + LVC_W'(1);
          state_d = ST_P1_RL;
        end
      end

      ST_P1_JMP: begin
        sum_d   = add_sum;
        x_d     = candx_q.anc;
        dx_d    = cdep_q;
        steps_d = steps_q + STEP_W'(1);
        state_d = ST_P1_TOP;
      end

      // phase two: lift both nodes until they meet
      ST_P2_TOP: begin
        if (steps_q == STEP_W'(STEP_LIMIT) || x_q == y_q) begin
          state_d = ST_FIN;
        end else begin
          lvl_d   = '0;
          state_d = ST_P2_RX;
        end
      end

      ST_P2_RX: begin
        lift_re    = 1'b1;
        lift_raddr = {node_addr(x_q), lvl_idx};
        state_d    = ST_P2_RY;
      end

      ST_P2_RY: begin
        ent_d      = lift_rd;
        lift_re    = 1'b1;
        lift_raddr = {node_addr(y_q), lvl_idx};
        state_d    = ST_P2_CK;
      end

      ST_P2_CK: begin
        brk = ent_q.anc == lift_rd.anc;
        if (lvl_q == '0 || !brk) begin
          candx_d = ent_q;
          candy_d = lift_rd;
        end
        if (brk || lvl_last) begin
          state_d = ST_P2_JX;
        end else begin
          lvl_d   = lvl_q + LVC_W'(1);
          state_d = ST_P2_RX;
        end
      end

      ST_P2_JX: begin
        sum_d   = add_sum;
        state_d = ST_P2_JY;
      end

      ST_P2_JY: begin
        sum_d   = add_sum;
        x_d     = candx_q.anc;
        y_d     = candy_q.anc;
        steps_d = steps_q + STEP_W'(1);
        state_d = ST_P2_TOP;
      end

      // hand the sum to the output register once it is free
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = sum_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    par_q      <= par_d;
    qa_q       <= qa_d;
    qb_q       <= qb_d;
    mid_q      <= mid_d;
    x_q        <= x_d;
    y_q        <= y_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    cdep_q     <= cdep_d;
    wacc_q     <= wacc_d;
    sum_q      <= sum_d;
    lvl_q      <= lvl_d;
    steps_q    <= steps_d;
    ent_q      <= ent_d;
    candx_q    <= candx_d;
    candy_q    <= candy_d;
    out_data_q <= out_data_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-SUM_W){1'b0}}, out_data_q};

endmodule

/* sv/tpdl_checker.sv */
// ----------------------------------------------------------------------------
// tpdl_checker
// Port-level checks of the tree path distance block, bound to its top level.
// ----------------------------------------------------------------------------
module tpdl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [tpdl_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  import tpdl_pkg::*;

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // a query always leaves the sequencer busy in the cycle after it is taken
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser_i == OP_QUERY |=> !s_axis_tready_o)
    else $error("ready right after a query word");

  // a load never produces a result word
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && s_axis_tuser_i == OP_LOAD && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result word after a load");

  // the sequencer is idle again as a new result lands
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("result word without a return to idle");

endmodule

bind tree_path_distance_lifting tpdl_checker u_tpdl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
